### hw/rtl/multi_channel_blink_pulse_driver_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BLINK_PULSE_DRIVER_DEFINES_SVH
`define MULTI_CHANNEL_BLINK_PULSE_DRIVER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MCBPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define MCBPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mcbpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbpd_pkg
// Types, codes and default values of the multi-channel blink/pulse driver.
// ----------------------------------------------------------------------------
package mcbpd_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNT_WIDTH_DEF  = 16;

    // Widths fixed by the word formats.
    localparam int OUT_BITS   = 4;
    localparam int CHAN_W     = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] BLINK_PERIOD_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] PULSE_LENGTH_RST = 16'd250;
    localparam logic [OUT_BITS-1:0]   ACTIVE_MASK_RST  = 4'hF;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_ON        = 3'd1,
        MODE_BLINK_ON  = 3'd2,
        MODE_BLINK_OFF = 3'd3,
        MODE_PULSE     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        EVT_OFF   = 2'd0,
        EVT_ON    = 2'd1,
        EVT_BLINK = 2'd2,
        EVT_PULSE = 2'd3
    } t_event;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_POST = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        REG_BLINK_PERIOD = 2'd0,
        REG_PULSE_LENGTH = 2'd1,
        REG_ACTIVE_MASK  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_req              req_type;
        logic [CHAN_W-1:0] channel;
        t_event            event_code;
    } t_in_word;

    typedef struct packed {
        logic [OUT_BITS-1:0] pin_levels;
        logic [OUT_BITS-1:0] busy_mask;
    } t_out_word;

    typedef struct packed {
        t_reg_idx              reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_word;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] blink_period;
        logic [CFG_DATA_W-1:0] pulse_length;
        logic [OUT_BITS-1:0]   active_level_mask;
    } t_cfg;

    typedef struct packed {
        logic   tick;
        logic   post;
        t_event evt;
    } t_chan_ctrl;

    typedef struct packed {
        logic active;
        logic busy;
    } t_chan_stat;

endpackage

### hw/rtl/mcbpd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbpd_stream_if
// Valid/ready channel that carries one word of a given type.
// ----------------------------------------------------------------------------
interface mcbpd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/mcbpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbpd_cfg_regs
// Configuration register file; takes one write per cycle.
// ----------------------------------------------------------------------------
module mcbpd_cfg_regs
    import mcbpd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcbpd_stream_if.sink  i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_BLINK_PERIOD: n_cfg.blink_period = i_cfg.data.wr_data;
                REG_PULSE_LENGTH: n_cfg.pulse_length = i_cfg.data.wr_data;
                REG_ACTIVE_MASK: begin
                    n_cfg.active_level_mask = i_cfg.data.wr_data[OUT_BITS-1:0];
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_period      <= BLINK_PERIOD_RST;
            r_cfg.pulse_length      <= PULSE_LENGTH_RST;
            r_cfg.active_level_mask <= ACTIVE_MASK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/mcbpd_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbpd_channel
// Mode state machine, phase countdown and pending event of one pin.
// ----------------------------------------------------------------------------
module mcbpd_channel
    import mcbpd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_chan_ctrl             i_ctrl,
    input  logic [COUNT_WIDTH-1:0] i_blink_reload,
    input  logic [COUNT_WIDTH-1:0] i_pulse_reload,
    output t_chan_stat             o_stat
);

    t_mode                  r_mode;
    t_mode                  n_mode;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_pend_valid;
    logic                   n_pend_valid;
    t_event                 r_pend_event;
    t_event                 n_pend_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_OFF;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_event <= EVT_OFF;
        end else begin
            r_mode       <= n_mode;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_pend_event <= n_pend_event;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_event = r_pend_event;

        if (i_ctrl.post) begin
            // A newer command replaces whatever is still waiting.
            n_pend_event = i_ctrl.evt;
            n_pend_valid = 1'b1;
        end else if (i_ctrl.tick) begin
            unique case (r_mode)
                MODE_OFF: begin
                    if (r_pend_valid) begin
                        unique case (r_pend_event)
                            EVT_ON: begin
                                n_mode       = MODE_ON;
                                n_pend_valid = 1'b0;
                            end
                            EVT_BLINK: begin
                                n_count      = i_blink_reload;
                                n_mode       = MODE_BLINK_ON;
                                n_pend_valid = 1'b0;
                            end
                            EVT_PULSE: begin
                                n_count      = i_pulse_reload;
                                n_mode       = MODE_PULSE;
                                n_pend_valid = 1'b0;
                            end
                            EVT_OFF: n_mode = MODE_OFF;
                        endcase
                    end
                end
                MODE_ON: begin
                    if (r_pend_valid && (r_pend_event == EVT_OFF)) begin
                        n_mode       = MODE_OFF;
                        n_pend_valid = 1'b0;
                    end else if (r_pend_valid && (r_pend_event == EVT_BLINK)) begin
                        n_count      = i_blink_reload;
                        n_mode       = MODE_BLINK_ON;
                        n_pend_valid = 1'b0;
                    end
                end
                MODE_BLINK_ON, MODE_BLINK_OFF: begin
                    if (r_count != '0) begin
                        n_count = r_count - COUNT_WIDTH'(1);
                    end else begin
                        n_count = i_blink_reload;
                        n_mode  = (r_mode == MODE_BLINK_ON) ? MODE_BLINK_OFF
                                                            : MODE_BLINK_ON;
                    end
                    // A pending on or off ends blinking after the phase step.
                    if (r_pend_valid && (r_pend_event == EVT_ON)) begin
                        n_count      = '0;
                        n_mode       = MODE_ON;
                        n_pend_valid = 1'b0;
                    end else if (r_pend_valid && (r_pend_event == EVT_OFF)) begin
                        n_count      = '0;
                        n_mode       = MODE_OFF;
                        n_pend_valid = 1'b0;
                    end
                end
                MODE_PULSE: begin
                    if (r_count != '0) begin
                        n_count = r_count - COUNT_WIDTH'(1);
                    end else begin
                        n_mode = MODE_OFF;
                    end
                end
                default: begin
                    n_count      = '0;
                    n_mode       = MODE_OFF;
                    n_pend_event = EVT_OFF;
                    n_pend_valid = 1'b0;
                end
            endcase
        end

        o_stat.active = (n_mode == MODE_ON) || (n_mode == MODE_BLINK_ON) ||
                        (n_mode == MODE_PULSE);
        o_stat.busy   = n_pend_valid;
    end

endmodule

### hw/rtl/multi_channel_blink_pulse_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_blink_pulse_driver
// Drives a set of pins in off, on, blink or single-pulse modes from tick
// and command words, and reports pin levels and pending commands.
//
//   Port     Dir   Word         Fields
//   i_in     in    t_in_word    req_type, channel, event_code
//   o_out    out   t_out_word   pin_levels, busy_mask
//   i_cfg    in    t_cfg_word   reg_index, wr_data
//
// One word is accepted per cycle while o_out does not stall; its result
// word passes through the input register and then the result register.
// When o_out stalls, one more word is held in the input register and then
// i_in.ready drops until the result is taken.
// i_cfg is always ready; a write takes effect on the next cycle.
// Synchronous reset puts every channel in off mode with nothing pending
// and loads the default configuration.
// ----------------------------------------------------------------------------
module multi_channel_blink_pulse_driver
    import mcbpd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcbpd_stream_if.sink   i_in,
    mcbpd_stream_if.source o_out,
    mcbpd_stream_if.sink   i_cfg
);

    logic      r_in_valid;
    t_in_word  r_in_item;
    logic      r_out_valid;
    t_out_word r_out_item;
    t_out_word n_out_item;

    logic      w_adv;
    logic      w_fire;
    t_cfg      w_cfg;

    logic [COUNT_WIDTH-1:0] w_blink_reload;
    logic [COUNT_WIDTH-1:0] w_pulse_reload;

    t_chan_ctrl w_ctrl [NUM_CHANNELS];
    t_chan_stat w_stat [NUM_CHANNELS];

    mcbpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_blink_reload = COUNT_WIDTH'(w_cfg.blink_period);
    assign w_pulse_reload = COUNT_WIDTH'(w_cfg.pulse_length);

    // The pipeline moves whenever the result register is free or being read.
    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
    end

    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
            always_comb begin
                w_ctrl[g].tick = w_fire && (r_in_item.req_type == REQ_TICK);
                w_ctrl[g].post = w_fire && (r_in_item.req_type == REQ_POST) &&
                                 (int'(r_in_item.channel) == g);
                w_ctrl[g].evt  = r_in_item.event_code;
            end

            mcbpd_channel #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_channel (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (w_ctrl[g]),
                .i_blink_reload (w_blink_reload),
                .i_pulse_reload (w_pulse_reload),
                .o_stat         (w_stat[g])
            );
        end

        // Only the low channels are visible in the result word.
        for (genvar b = 0; b < OUT_BITS; b++) begin : g_bit
            if (b < NUM_CHANNELS) begin : g_used
                assign n_out_item.pin_levels[b] =
                    (w_stat[b].active == w_cfg.active_level_mask[b]);
                assign n_out_item.busy_mask[b]  = w_stat[b].busy;
            end else begin : g_unused
                assign n_out_item.pin_levels[b] = 1'b0;
                assign n_out_item.busy_mask[b]  = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

### hw/rtl/mcbpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbpd_checker
// Port-level checks on the driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_channel_blink_pulse_driver_defines.svh"

module mcbpd_checker
    import mcbpd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // A result word that waits must keep its value.
    `MCBPD_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "result word changed while stalled")

    // Reset empties the result register.
    `MCBPD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Input back-pressure only comes from a stalled result.
    `MCBPD_ASSERT(a_bp_cause, i_clk, i_rst_n, !i_in_ready |-> (i_out_valid && !i_out_ready), "input stalled without an output stall")

    // A new result always stems from a word accepted earlier at the input.
    `MCBPD_ASSERT(a_out_src, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "result word without an accepted input word")

endmodule

bind multi_channel_blink_pulse_driver mcbpd_checker u_mcbpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
